### rtl/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

    // Width and reset value of the active_frames register
    localparam int ACTIVE_W = 4;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // Fixed result field widths
    localparam int SLOT_OUT_W  = 3;
    localparam int FAULT_W     = 32;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

endpackage

`default_nettype wire

### rtl/lfu_page_replacement_unit.sv
`default_nettype none

// LFU page replacement frame table.
// s_ channel: one page reference per transfer (s_tdata = page number).
// m_ channel: one result per reference (hit, slot, evicted flag and page,
// saturating fault total).
// APB port: register 0 at address 0 holds active_frames (0 acts as 1,
// values above NUM_FRAMES act as NUM_FRAMES). Write it only while idle.
// Each reference sends a search token down a chain of NUM_FRAMES cells, one
// cell per cycle; the frame update is broadcast once the token leaves the
// last cell. A new reference is taken only while the sequencer is idle, that
// is once the previous reference has committed its update and its result.
// The result sits in an output register; while the receiver stalls, the next
// reference is still taken and searched, and its update waits until the
// output register is free.
// Reset empties all frames, clears use counts and the fault total, and sets
// active_frames to 8.

module lfu_page_replacement_unit
    import lfu_pkg::*;
#(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: page_number[PAGE_BITS-1:0]
    input  wire logic [((PAGE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: hit, slot[3], evicted_valid, evicted_page[PAGE_BITS], fault_total[32]
    output logic [((PAGE_BITS+37+7)/8)*8-1:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SLOT_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int USE_BITS  = $clog2(NUM_FRAMES + 1);
    localparam int CMP_BITS  = (USE_BITS > ACTIVE_W) ? USE_BITS : ACTIVE_W;
    localparam int OUT_W     = ((PAGE_BITS + 37 + 7) / 8) * 8;

    typedef struct packed {
        logic                  active;
        logic [PAGE_BITS-1:0]  page;
        logic                  hit;
        logic [SLOT_BITS-1:0]  hit_slot;
        logic                  empty_found;
        logic [SLOT_BITS-1:0]  empty_slot;
        logic [COUNT_BITS-1:0] min_count;
        logic [SLOT_BITS-1:0]  min_slot;
        logic [PAGE_BITS-1:0]  min_page;
    } tok_t;

    typedef struct packed {
        logic                 wr;
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

    state_t                state_reg, state_next;
    logic [ACTIVE_W-1:0]   active_reg;
    logic [FAULT_W-1:0]    fault_reg, fault_next;
    tok_t                  held_reg;
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;
    logic [USE_BITS-1:0]   frames_in_use;
    logic [CMP_BITS-1:0]   active_ext;
    tok_t                  chain [NUM_FRAMES+1];
    upd_t                  upd;
    logic                  commit;
    logic [SLOT_BITS-1:0]  dec_slot;
    logic                  ev_valid;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [SLOT_BITS+2:0]  slot_wide;
    logic                  cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == 2'b00) ? 32'(active_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (cfg_wr) begin
            active_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    // Clamp the active frame count into 1 .. NUM_FRAMES
    always_comb begin
        active_ext = CMP_BITS'(active_reg);
        if (active_ext == '0) begin
            frames_in_use = USE_BITS'(1);
        end else if (active_ext > CMP_BITS'(NUM_FRAMES)) begin
            frames_in_use = USE_BITS'(NUM_FRAMES);
        end else begin
            frames_in_use = active_ext[USE_BITS-1:0];
        end
    end

    // Launch a token into the first cell on each input transfer
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        chain[0]        = '0;
        chain[0].active = s_tvalid && s_tready;
        chain[0].page   = s_tdata[PAGE_BITS-1:0];
    end

    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        lfu_cell #(
            .CELL_INDEX (g),
            .PAGE_BITS  (PAGE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .SLOT_BITS  (SLOT_BITS),
            .USE_BITS   (USE_BITS),
            .tok_t      (tok_t),
            .upd_t      (upd_t)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .frames_in_use (frames_in_use),
            .tok_in        (chain[g]),
            .tok_out       (chain[g+1]),
            .upd           (upd)
        );
    end

    // Sequencer
    assign commit = (state_reg == ST_COMMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (chain[NUM_FRAMES].active) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the finished token until the update can go out
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SEARCH) && chain[NUM_FRAMES].active) begin
            held_reg <= chain[NUM_FRAMES];
        end
    end

    // Pick hit slot, first empty frame, or least used frame
    always_comb begin
        ev_valid = 1'b0;
        ev_page  = '0;
        if (held_reg.hit) begin
            dec_slot = held_reg.hit_slot;
        end else if (held_reg.empty_found) begin
            dec_slot = held_reg.empty_slot;
        end else begin
            dec_slot = held_reg.min_slot;
            ev_valid = 1'b1;
            ev_page  = held_reg.min_page;
        end
    end

    always_comb begin
        upd.wr   = commit;
        upd.hit  = held_reg.hit;
        upd.slot = dec_slot;
        upd.page = held_reg.page;
    end

    // Saturating fault total
    always_comb begin
        fault_next = fault_reg;
        if (!held_reg.hit && !(&fault_reg)) begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= '0;
        end else if (commit) begin
            fault_reg <= fault_next;
        end
    end

    // Output register
    assign slot_wide   = {3'b000, dec_slot};
    assign m_data_next = OUT_W'({fault_next, ev_page, ev_valid,
                                 slot_wide[SLOT_OUT_W-1:0], held_reg.hit});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // A token leaves the chain only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        chain[NUM_FRAMES].active |-> (state_reg == ST_SEARCH))
        else $error("token left the cell chain outside the search phase");

    // An update is committed only into a free or draining output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!m_valid_reg || m_tready))
        else $error("result committed over an unread result");

    // The fault total never goes down
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (fault_reg >= $past(fault_reg)))
        else $error("fault total decreased");
`endif

endmodule

`default_nettype wire

### rtl/lfu_cell.sv
`default_nettype none

module lfu_cell #(
    parameter int CELL_INDEX = 0,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16,
    parameter int SLOT_BITS  = 3,
    parameter int USE_BITS   = 4,
    parameter type tok_t     = logic,
    parameter type upd_t     = logic
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [USE_BITS-1:0] frames_in_use,
    input  wire tok_t                tok_in,
    output tok_t                     tok_out,
    input  wire upd_t                upd
);

    localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(CELL_INDEX);
    localparam logic [USE_BITS-1:0]  MY_NUM  = USE_BITS'(CELL_INDEX);

    logic                  valid_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [COUNT_BITS-1:0] count_reg;
    tok_t                  tok_reg;
    tok_t                  tok_next;

    // Fold this frame into the search token when the frame is in use
    always_comb begin
        tok_next = tok_in;
        if (tok_in.active && (MY_NUM < frames_in_use)) begin
            if (!tok_in.hit && valid_reg && (page_reg == tok_in.page)) begin
                tok_next.hit      = 1'b1;
                tok_next.hit_slot = MY_SLOT;
            end
            if (!tok_in.empty_found && !valid_reg) begin
                tok_next.empty_found = 1'b1;
                tok_next.empty_slot  = MY_SLOT;
            end
            // first frame seeds the minimum; later ones replace it only when strictly lower
            if ((CELL_INDEX == 0) || (count_reg < tok_in.min_count)) begin
                tok_next.min_count = count_reg;
                tok_next.min_slot  = MY_SLOT;
                tok_next.min_page  = page_reg;
            end
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // Apply the update broadcast to this frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            page_reg  <= '0;
            count_reg <= '0;
        end else if (upd.wr && (upd.slot == MY_SLOT)) begin
            if (upd.hit) begin
                if (!(&count_reg)) begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
            end else begin
                valid_reg <= 1'b1;
                page_reg  <= upd.page;
                count_reg <= COUNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

### tb/lfu_frame_checker.sv
`default_nettype none

// Watch both streams and the APB port, track the frame table, and compare
// every result transfer against the oldest predicted result.
module lfu_frame_checker
    import lfu_pkg::*;
#(
    parameter logic [1:0] ACTIVE_ADDR = 2'd0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // tdata: page_number[15:0]
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // tdata: hit, slot[3], evicted_valid, evicted_page[16], fault_total[32], pad[3]
    input  wire logic [55:0] m_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               outstanding
);

    localparam int FRAMES = 8;
    localparam logic [15:0] USES_MAX = 16'hFFFF;
    localparam logic [FAULT_W-1:0] FAULTS_MAX = '1;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted_valid;
        logic [15:0]           evicted_page;
        logic [FAULT_W-1:0]    fault_total;
    } frame_result_t;

    logic [15:0]         frame_tag  [FRAMES];
    logic                frame_live [FRAMES];
    logic [15:0]         frame_uses [FRAMES];
    logic [FAULT_W-1:0]  faults_seen;
    logic [ACTIVE_W-1:0] active_cfg;
    frame_result_t       pending_results [$];
    frame_result_t       want;
    frame_result_t       got;
    int                  errors = 0;

    // Look up one page reference and update the frame table
    function automatic frame_result_t replace_lfu(input logic [15:0] page);
        frame_result_t res;
        int span;
        int idx;
        bit found;
        res = '0;
        idx = 0;
        found = 1'b0;
        span = (active_cfg == 0) ? 1 :
               ((int'(active_cfg) > FRAMES) ? FRAMES : int'(active_cfg));
        // search active frames, lowest index first
        for (int i = 0; i < span; i++) begin
            if (!found && frame_live[i] && frame_tag[i] == page) begin
                found = 1'b1;
                idx = i;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (frame_uses[idx] != USES_MAX)
                frame_uses[idx] = frame_uses[idx] + 16'd1;
        end else begin
            // take the lowest empty frame
            for (int i = 0; i < span; i++) begin
                if (!found && !frame_live[i]) begin
                    found = 1'b1;
                    idx = i;
                end
            end
            // otherwise evict the least used frame, lowest index on ties
            if (!found) begin
                idx = 0;
                for (int i = 1; i < span; i++) begin
                    if (frame_uses[i] < frame_uses[idx])
                        idx = i;
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = frame_tag[idx];
            end
            frame_tag[idx] = page;
            frame_live[idx] = 1'b1;
            frame_uses[idx] = 16'd1;
            if (faults_seen != FAULTS_MAX)
                faults_seen = faults_seen + 1'b1;
        end
        res.slot = idx[SLOT_OUT_W-1:0];
        res.fault_total = faults_seen;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAMES; i++) begin
                frame_tag[i] = '0;
                frame_live[i] = 1'b0;
                frame_uses[i] = '0;
            end
            faults_seen = '0;
            active_cfg = ACTIVE_RESET;
            pending_results.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready && paddr == ACTIVE_ADDR)
                active_cfg = pwdata[ACTIVE_W-1:0];

            // compare each result transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.hit           = m_tdata[0];
                got.slot          = m_tdata[3:1];
                got.evicted_valid = m_tdata[4];
                got.evicted_page  = m_tdata[20:5];
                got.fault_total   = m_tdata[52:21];
                if (pending_results.size() == 0) begin
                    $error("result transfer with no reference pending");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        errors++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, got.slot);
                        errors++;
                    end
                    if (got.evicted_valid !== want.evicted_valid) begin
                        $error("evicted_valid: expected %0d, got %0d",
                               want.evicted_valid, got.evicted_valid);
                        errors++;
                    end
                    if (got.evicted_page !== want.evicted_page) begin
                        $error("evicted_page: expected 0x%04h, got 0x%04h",
                               want.evicted_page, got.evicted_page);
                        errors++;
                    end
                    if (got.fault_total !== want.fault_total) begin
                        $error("fault_total: expected %0d, got %0d",
                               want.fault_total, got.fault_total);
                        errors++;
                    end
                end
            end

            // predict the result of each accepted reference
            if (s_tvalid && s_tready)
                pending_results.push_back(replace_lfu(s_tdata));
        end
        outstanding <= pending_results.size();
        fail_count <= errors;
    end

endmodule

`default_nettype wire

### tb/lfu_page_replacement_unit_tb.sv
`default_nettype none

module lfu_page_replacement_unit_tb
    import lfu_pkg::*;
;

    localparam logic [1:0] ACTIVE_ADDR = 2'd0;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_SIZE = 12;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    logic [15:0] page_pool [POOL_SIZE];

    lfu_page_replacement_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lfu_frame_checker #(.ACTIVE_ADDR(ACTIVE_ADDR)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result stream in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if (aresetn && !quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 5);
            m_tready <= 1'b0;
        end
    end

    // Offer one page reference, with an optional idle burst ahead of it
    task automatic send_page(input logic [15:0] page);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= page;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // APB write of active_frames: setup then access
    task automatic write_active(input logic [ACTIVE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ACTIVE_ADDR;
        pwdata <= {28'($urandom()), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [ACTIVE_W-1:0] setting;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill from empty, page zero and all-ones, repeated hits
        write_active(4'd8);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h8000);
        send_page(16'h0001);
        send_page(16'h5A5A);
        send_page(16'h7FFF);
        send_page(16'h00FF);
        send_page(16'hFF00);
        // full table: evict least used, ties to the lowest index
        send_page(16'hAAAA);
        send_page(16'h5555);

        // zero active frames acts as one
        wait_drained();
        write_active(4'd0);
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h1234);

        // oversize setting clamps to all frames
        wait_drained();
        write_active(4'd15);
        send_page(16'h7FFF);
        send_page(16'h00FF);

        // shrink, refill a page held above the limit, then grow: duplicate copy
        wait_drained();
        write_active(4'd2);
        send_page(16'h7FFF);
        send_page(16'hFF00);
        wait_drained();
        write_active(4'd8);
        send_page(16'h7FFF);
        send_page(16'hFF00);

        // random references, skewed over a small pool so hits and evictions dominate
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            if (ph == RANDOM_PHASES - 1)
                quiet <= 1'b1;
            setting = (ph == 0) ? 4'd1 :
                      (ph == 2) ? 4'd8 :
                      (ph == RANDOM_PHASES - 1) ? 4'd15 : 4'($urandom_range(0, 15));
            write_active(setting);
            foreach (page_pool[k])
                page_pool[k] = 16'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 6) == 0)
                    send_page(16'($urandom()));
                else
                    send_page(page_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))]);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
